@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the force accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, c, rn, expr) \
  lbl: assert property (@(posedge c) disable iff (!rn) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, c, rn, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, c, rn, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, c, rn, expr)
`define ASSERT_IMPLY(lbl, c, rn, ante, cons)
`define ASSERT_NEXT(lbl, c, rn, ante, cons)
`endif
`endif

@@ src/flfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Force accumulator package
// Beat types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package flfa_pkg;

  localparam int MAX_FORCES_DEF = 16;
  localparam int Q_FRAC         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int ACTIVE_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd4;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_CALC = 1'b1;

  localparam logic signed [31:0] DIR_Y_RESET = -32'sd65536;

  typedef struct packed {
    logic              action;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0]   sum_x;
    logic signed [31:0]   sum_y;
    logic signed [31:0]   sum_z;
    logic                 add_dropped;
    logic [ACTIVE_W-1:0]  active_count;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } entry_t;

endpackage

@@ src/flfa_friction_unit.sv @@
// ----------------------------------------------------------------------------
// Friction unit
// Moves each axis of one force entry toward zero and flags an all-zero result.
// ----------------------------------------------------------------------------
module flfa_friction_unit (
  input  flfa_pkg::entry_t ent,
  input  logic [30:0]      fric,
  output flfa_pkg::entry_t res,
  output logic             all_zero
);

  function automatic logic signed [31:0] rub(input logic signed [31:0] a,
                                             input logic [30:0] f);
    logic signed [32:0] ax;
    logic signed [32:0] fx;
    logic signed [32:0] d;
    logic signed [31:0] r;
    ax = {a[31], a};
    fx = {2'b00, f};
    r  = a;
    if (a > 32'sd0) begin
      d = ax - fx;
      r = (d <= 33'sd0) ? 32'sd0 : d[31:0];
    end else if (a < 32'sd0) begin
      d = ax + fx;
      r = (d >= 33'sd0) ? 32'sd0 : d[31:0];
    end
    return r;
  endfunction

  always_comb begin
    res.x    = rub(ent.x, fric);
    res.y    = rub(ent.y, fric);
    res.z    = rub(ent.z, fric);
    all_zero = (res.x == 32'sd0) && (res.y == 32'sd0) && (res.z == 32'sd0);
  end

endmodule

@@ src/force_list_friction_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// Force list friction accumulator core
// Keeps an ordered table of Q16.16 force vectors; a calculate beat applies
// friction, compacts the table and returns gravity plus forces, saturated.
//
//   channel  ports                          handshake
//   input    start, busy, in_data           taken when start and not busy
//   result   out_strobe, out_data           one cycle, cannot be held off
//   config   cfg_we, cfg_idx, cfg_wdata     written when cfg_we is high
//
// An add beat's result shows in the next cycle.
// A calculate beat forms gravity per axis in turn, then reads each stored
// entry through the table read port and applies friction to it.
// Reset is synchronous and needs no clearing pass; the table is only read
// below the entry count. The result side cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module force_list_friction_accumulator_core #(
  parameter int MAX_FORCES = flfa_pkg::MAX_FORCES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  flfa_pkg::in_t                         in_data,
  output logic                                  out_strobe,
  output flfa_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [flfa_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [flfa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_FORCES + 1);
  localparam int IDX_W  = (MAX_FORCES > 1) ? $clog2(MAX_FORCES) : 1;
  localparam int ACC_W  = (((32 + CNT_W) > 48) ? (32 + CNT_W) : 48) + 1;
  localparam int OUT_CW = flfa_pkg::ACTIVE_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FORCES);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GRAV = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] grav_r;
  logic [30:0]        fric_r;
  logic signed [31:0] dir_x_r;
  logic signed [31:0] dir_y_r;
  logic signed [31:0] dir_z_r;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    kept_r, kept_nxt;
  logic [CNT_W-1:0]    rd_i_r, rd_i_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [1:0]          grav_k_r, grav_k_nxt;
  logic signed [63:0]  prod_r, prod_nxt;
  logic                prod_vld_r, prod_vld_nxt;
  logic [1:0]          prod_k_r, prod_k_nxt;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic                out_valid_r, out_valid_nxt;
  flfa_pkg::out_t      out_data_r, out_data_nxt;

  logic signed [31:0]  dir_sel;
  logic                accept;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  flfa_pkg::entry_t    mem_wdata;
  flfa_pkg::entry_t    rd_data_r;
  flfa_pkg::entry_t    rub_res;
  logic                rub_zero;
  logic signed [31:0]  rub_ax [3];

  flfa_pkg::entry_t mem [MAX_FORCES];

  flfa_friction_unit u_fric (
    .ent      (rd_data_r),
    .fric     (fric_r),
    .res      (rub_res),
    .all_zero (rub_zero)
  );

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;
  assign rd_en      = (state_r == ST_WALK) && (rd_i_r < count_r);
  assign rd_addr    = rd_i_r[IDX_W-1:0];

  assign rub_ax[0] = rub_res.x;
  assign rub_ax[1] = rub_res.y;
  assign rub_ax[2] = rub_res.z;

  always_comb begin
    unique case (grav_k_r)
      2'd0:    dir_sel = dir_x_r;
      2'd1:    dir_sel = dir_y_r;
      default: dir_sel = dir_z_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    kept_nxt      = kept_r;
    rd_i_nxt      = rd_i_r;
    rd_vld_nxt    = 1'b0;
    grav_k_nxt    = grav_k_r;
    prod_nxt      = prod_r;
    prod_vld_nxt  = 1'b0;
    prod_k_nxt    = prod_k_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_W-1:0];
    mem_wdata     = '{x: in_data.vel_x, y: in_data.vel_y, z: in_data.vel_z};
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = acc_r[k];
    end

    if (prod_vld_r) begin
      acc_nxt[prod_k_r] = ACC_W'(prod_r >>> flfa_pkg::Q_FRAC);
    end

    if (rd_vld_r && !rub_zero) begin
      mem_we    = 1'b1;
      mem_waddr = kept_r[IDX_W-1:0];
      mem_wdata = rub_res;
      kept_nxt  = kept_r + CNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        acc_nxt[k] = acc_r[k] + ACC_W'(rub_ax[k]);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == flfa_pkg::ACT_ADD) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.sum_x       = '0;
            out_data_nxt.sum_y       = '0;
            out_data_nxt.sum_z       = '0;
            if (count_r < MAX_CNT) begin
              mem_we                   = 1'b1;
              count_nxt                = count_r + CNT_W'(1);
              out_data_nxt.add_dropped = 1'b0;
            end else begin
              out_data_nxt.add_dropped = 1'b1;
            end
            out_data_nxt.active_count = OUT_CW'(count_nxt);
          end else begin
            state_nxt  = ST_GRAV;
            grav_k_nxt = 2'd0;
            kept_nxt   = '0;
          end
        end
      end
      ST_GRAV: begin
        prod_nxt     = grav_r * dir_sel;
        prod_vld_nxt = 1'b1;
        prod_k_nxt   = grav_k_r;
        grav_k_nxt   = grav_k_r + 2'd1;
        if (grav_k_r == 2'd2) begin
          state_nxt = ST_WALK;
          rd_i_nxt  = '0;
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          rd_vld_nxt = 1'b1;
          rd_i_nxt   = rd_i_r + CNT_W'(1);
        end else if (!rd_vld_r && !prod_vld_r) begin
          state_nxt                 = ST_IDLE;
          count_nxt                 = kept_r;
          out_valid_nxt             = 1'b1;
          out_data_nxt.sum_x        = sat32(acc_r[0]);
          out_data_nxt.sum_y        = sat32(acc_r[1]);
          out_data_nxt.sum_z        = sat32(acc_r[2]);
          out_data_nxt.add_dropped  = 1'b0;
          out_data_nxt.active_count = OUT_CW'(kept_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= '0;
      fric_r  <= '0;
      dir_x_r <= '0;
      dir_y_r <= flfa_pkg::DIR_Y_RESET;
      dir_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        flfa_pkg::CFG_GRAVITY:  grav_r  <= cfg_wdata;
        flfa_pkg::CFG_FRICTION: fric_r  <= cfg_wdata[30:0];
        flfa_pkg::CFG_DIR_X:    dir_x_r <= cfg_wdata;
        flfa_pkg::CFG_DIR_Y:    dir_y_r <= cfg_wdata;
        flfa_pkg::CFG_DIR_Z:    dir_z_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      kept_r      <= '0;
      rd_i_r      <= '0;
      rd_vld_r    <= 1'b0;
      grav_k_r    <= '0;
      prod_vld_r  <= 1'b0;
      prod_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      kept_r      <= kept_nxt;
      rd_i_r      <= rd_i_nxt;
      rd_vld_r    <= rd_vld_nxt;
      grav_k_r    <= grav_k_nxt;
      prod_vld_r  <= prod_vld_nxt;
      prod_k_r    <= prod_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= MAX_CNT)
  `ASSERT_NEXT(a_add_result, clk, rst_n, accept && (in_data.action == flfa_pkg::ACT_ADD), out_strobe)
  `ASSERT_IMPLY(a_no_result_busy, clk, rst_n, busy, !out_strobe)
  `ASSERT_IMPLY(a_compact_behind, clk, rst_n, state_r == ST_WALK, kept_r <= rd_i_r)
  `ASSERT_IMPLY(a_read_in_table, clk, rst_n, rd_en, rd_i_r < MAX_CNT)

endmodule
